>>> rtl/kmd_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Key matrix debounce package
// Shared types and constants for the debounce and encoder block.
// ----------------------------------------------------------------------------
package kmd_pkg;

  localparam int          COLS        = 16;
  localparam logic [3:0]  ENC_COL     = 4'd15;
  localparam logic [2:0]  FILTER_MASK = 3'b111;
  localparam logic [7:0]  RAW_DOWN    = 8'h80;
  localparam logic [7:0]  CNT_MAX     = 8'hFF;
  localparam logic [7:0]  DOWN_RST    = 8'hFF;
  localparam logic [7:0]  UP_RST      = 8'h00;
  localparam logic [15:0] IDLE_MS_RST = 16'd400;
  localparam int          CFG_IDX_W   = 2;
  localparam int          CFG_DATA_W  = 16;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_DOWN_LEVEL = 2'd0,
    REG_UP_LEVEL   = 2'd1,
    REG_ENC_IDLE   = 2'd2
  } cfg_reg_t;

  typedef struct packed {
    logic [7:0]  down_level;
    logic [7:0]  up_level;
    logic [15:0] encoder_idle_ms;
  } cfg_t;

  typedef struct packed {
    logic [2:0]  row;
    logic [3:0]  column;
    logic        key_pressed;
    logic [15:0] time_ms;
    logic        last_in_scan;
  } in_item_t;

  typedef struct packed {
    logic [2:0]  out_row;
    logic [3:0]  out_column;
    logic        key_down;
    logic [15:0] row_state;
    logic [7:0]  active_count;
    logic        scan_done;
  } out_item_t;

  typedef struct packed {
    logic [2:0] row;
    logic [3:0] column;
    logic       in_range;
    logic [7:0] sample;
    logic       last;
  } work_t;

endpackage

>>> rtl/kmd_in_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Sample request channel
// Valid/ready channel carrying one sampled matrix switch.
// ----------------------------------------------------------------------------
interface kmd_in_if import kmd_pkg::*; ();
  logic     valid;
  logic     ready;
  in_item_t data;

  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

>>> rtl/kmd_out_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Result request channel
// Valid/ready channel carrying one debounced key result.
// ----------------------------------------------------------------------------
interface kmd_out_if import kmd_pkg::*; ();
  logic      valid;
  logic      ready;
  out_item_t data;

  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

>>> rtl/kmd_cfg_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Configuration write channel
// Valid/ready channel carrying a register index and write data.
// ----------------------------------------------------------------------------
interface kmd_cfg_if import kmd_pkg::*; ();
  logic                  valid;
  logic                  ready;
  logic [CFG_IDX_W-1:0]  index;
  logic [CFG_DATA_W-1:0] data;

  modport source (output valid, output index, output data, input ready);
  modport sink (input valid, input index, input data, output ready);
endinterface

>>> rtl/key_matrix_debounce_encoder_unit.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Key matrix debounce and encoder unit
// Per-key shift-register debounce with a rotary encoder filter on column 15.
// ----------------------------------------------------------------------------
// Usage:
//   in_ch  - one sampled switch per request (row, column, level, time, end mark).
//   out_ch - one result per request, in order: debounced bit, row word,
//            running count of active keys and the end-of-scan flag.
//   cfg_ch - register writes (down level, up level, encoder idle time); always
//            ready, write only while no request is in flight.
// Timing: one request per cycle sustained while out_ch is ready. A request
//   passes the queue, update stage and output register. The history update
//   is a registered memory read followed by a write on retire, with the last
//   write forwarded so consecutive samples of the same key stay back to back.
// Reset: registers return to their reset values and all key histories read as
//   zero at once through per-key valid bits; no clearing pass is run.
// Stall: while out_ch is not ready the result and the update stage hold, the
//   two-entry queue fills, and in_ch.ready drops when it is full.
// ----------------------------------------------------------------------------
module key_matrix_debounce_encoder_unit import kmd_pkg::*; #(
  parameter int ROWS = 8
) (
  input  logic clk,
  input  logic rst_n,
  kmd_in_if.sink    in_ch,
  kmd_out_if.source out_ch,
  kmd_cfg_if.sink   cfg_ch
);

  cfg_t  cfg_r;
  logic  push_vld;
  logic  push_rdy;
  work_t push_data;
  logic  pop_vld;
  logic  pop_rdy;
  work_t pop_data;

  assign cfg_ch.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.down_level      <= DOWN_RST;
      cfg_r.up_level        <= UP_RST;
      cfg_r.encoder_idle_ms <= IDLE_MS_RST;
    end else if (cfg_ch.valid) begin
      case (cfg_reg_t'(cfg_ch.index))
        REG_DOWN_LEVEL: cfg_r.down_level      <= cfg_ch.data[7:0];
        REG_UP_LEVEL:   cfg_r.up_level        <= cfg_ch.data[7:0];
        REG_ENC_IDLE:   cfg_r.encoder_idle_ms <= cfg_ch.data[15:0];
        default: begin
        end
      endcase
    end
  end

  kmd_front #(.ROWS(ROWS)) u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_ch     (in_ch),
    .cfg       (cfg_r),
    .push_vld  (push_vld),
    .push_data (push_data),
    .push_rdy  (push_rdy)
  );

  kmd_fifo u_fifo (
    .clk       (clk),
    .rst_n     (rst_n),
    .push_vld  (push_vld),
    .push_data (push_data),
    .push_rdy  (push_rdy),
    .pop_vld   (pop_vld),
    .pop_data  (pop_data),
    .pop_rdy   (pop_rdy)
  );

  kmd_back #(.ROWS(ROWS)) u_back (
    .clk      (clk),
    .rst_n    (rst_n),
    .cfg      (cfg_r),
    .pop_vld  (pop_vld),
    .pop_data (pop_data),
    .pop_rdy  (pop_rdy),
    .out_ch   (out_ch)
  );

endmodule

>>> rtl/kmd_front.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Key matrix debounce front end
// Accepts samples, checks the row range, runs the rotary encoder filter and
// forms the sample byte that enters the key history.
// ----------------------------------------------------------------------------
module kmd_front import kmd_pkg::*; #(
  parameter int ROWS = 8
) (
  input  logic  clk,
  input  logic  rst_n,
  kmd_in_if.sink in_ch,
  input  cfg_t  cfg,
  output logic  push_vld,
  output work_t push_data,
  input  logic  push_rdy
);

  logic        accept;
  logic        in_range;
  logic        is_enc;
  logic        dir;
  logic [2:0]  target;
  logic [15:0] elapsed;
  logic [7:0]  sample;

  logic [1:0]  phase_r, phase_nxt;
  logic [2:0]  filter_r, filter_nxt;
  logic [15:0] stamp_r, stamp_nxt;

  assign in_ch.ready = push_rdy;
  assign accept      = in_ch.valid && push_rdy;
  assign in_range    = 32'(in_ch.data.row) < 32'(ROWS);
  assign is_enc      = in_range && (in_ch.data.row[2:1] == 2'b00) &&
                       (in_ch.data.column == ENC_COL);
  assign dir         = in_ch.data.row[0];
  assign target      = dir ? FILTER_MASK : 3'b000;
  assign elapsed     = in_ch.data.time_ms - stamp_r;

  always_comb begin
    logic [2:0] filt;
    filt       = filter_r;
    phase_nxt  = phase_r;
    stamp_nxt  = stamp_r;
    sample     = in_ch.data.key_pressed ? RAW_DOWN : 8'h00;
    if (is_enc) begin
      sample = 8'h00;
      if (elapsed > cfg.encoder_idle_ms) begin
        filt = target;
      end
      if (in_ch.data.key_pressed != phase_r[dir]) begin
        phase_nxt[dir] = in_ch.data.key_pressed;
        if (!in_ch.data.key_pressed && !phase_r[!dir]) begin
          filt = {filt[1:0], dir};
          if (filt == target) begin
            stamp_nxt = in_ch.data.time_ms;
            sample    = cfg.down_level;
          end
        end
      end
    end
    filter_nxt = filt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r  <= 2'b00;
      filter_r <= 3'b000;
      stamp_r  <= 16'h0000;
    end else if (accept && is_enc) begin
      phase_r  <= phase_nxt;
      filter_r <= filter_nxt;
      stamp_r  <= stamp_nxt;
    end
  end

  assign push_vld            = in_ch.valid;
  assign push_data.row       = in_ch.data.row;
  assign push_data.column    = in_ch.data.column;
  assign push_data.in_range  = in_range;
  assign push_data.sample    = sample;
  assign push_data.last      = in_ch.data.last_in_scan;

endmodule

>>> rtl/kmd_fifo.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Key matrix debounce work queue
// Two-entry queue between the front end and the history update.
// ----------------------------------------------------------------------------
module kmd_fifo import kmd_pkg::*; (
  input  logic  clk,
  input  logic  rst_n,
  input  logic  push_vld,
  input  work_t push_data,
  output logic  push_rdy,
  output logic  pop_vld,
  output work_t pop_data,
  input  logic  pop_rdy
);

  work_t      mem_r [2];
  logic       wr_ptr_r;
  logic       rd_ptr_r;
  logic [1:0] cnt_r;
  logic       do_push;
  logic       do_pop;

  assign push_rdy = cnt_r != 2'd2;
  assign pop_vld  = cnt_r != 2'd0;
  assign pop_data = mem_r[rd_ptr_r];
  assign do_push  = push_vld && push_rdy;
  assign do_pop   = pop_vld && pop_rdy;

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem_r[wr_ptr_r] <= push_data;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= 1'b0;
      rd_ptr_r <= 1'b0;
      cnt_r    <= 2'd0;
    end else begin
      if (do_push) begin
        wr_ptr_r <= !wr_ptr_r;
      end
      if (do_pop) begin
        rd_ptr_r <= !rd_ptr_r;
      end
      cnt_r <= cnt_r + {1'b0, do_push} - {1'b0, do_pop};
    end
  end

endmodule

>>> rtl/kmd_back.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Key matrix debounce back end
// Read-modify-write of the key history with forwarding, row state update,
// scan counting and the result register.
// ----------------------------------------------------------------------------
module kmd_back import kmd_pkg::*; #(
  parameter int ROWS = 8
) (
  input  logic   clk,
  input  logic   rst_n,
  input  cfg_t   cfg,
  input  logic   pop_vld,
  input  work_t  pop_data,
  output logic   pop_rdy,
  kmd_out_if.source out_ch
);

  localparam int DEPTH = ROWS * COLS;
  localparam int IDX_W = $clog2(DEPTH);
  localparam int ROW_W = $clog2(ROWS);

  logic [7:0]       hist_mem [DEPTH];
  logic [DEPTH-1:0] hist_vld_r;
  logic [15:0]      row_bits_r [ROWS];

  logic             a_vld_r;
  work_t            a_r;
  logic [7:0]       mem_q_r;
  logic             fwd_vld_r;
  logic [IDX_W-1:0] fwd_idx_r;
  logic [7:0]       fwd_h_r;
  logic [7:0]       scan_cnt_r;
  logic             out_vld_r;
  out_item_t        out_r;

  logic [IDX_W-1:0] q_idx;
  logic [IDX_W-1:0] a_idx;
  logic [ROW_W-1:0] a_row;
  logic             out_adv;
  logic             a_load;
  logic [7:0]       h_old;
  logic [7:0]       h_new;
  logic [15:0]      mask;
  logic [15:0]      rb_new;
  logic [7:0]       cnt_new;
  out_item_t        res;

  assign q_idx   = IDX_W'({pop_data.row, pop_data.column});
  assign a_idx   = IDX_W'({a_r.row, a_r.column});
  assign a_row   = ROW_W'(a_r.row);
  assign out_adv = a_vld_r && (!out_vld_r || out_ch.ready);
  assign a_load  = pop_vld && (!a_vld_r || out_adv);
  assign pop_rdy = !a_vld_r || out_adv;

  always_comb begin
    if (fwd_vld_r && fwd_idx_r == a_idx) begin
      h_old = fwd_h_r;
    end else if (hist_vld_r[a_idx]) begin
      h_old = mem_q_r;
    end else begin
      h_old = 8'h00;
    end
    h_new = {1'b0, h_old[7:1]} | a_r.sample;
    mask  = 16'h0001 << a_r.column;
    if (h_new >= cfg.down_level) begin
      rb_new = row_bits_r[a_row] | mask;
    end else if (h_new <= cfg.up_level) begin
      rb_new = row_bits_r[a_row] & ~mask;
    end else begin
      rb_new = row_bits_r[a_row];
    end
    cnt_new = scan_cnt_r;
    if (a_r.in_range && h_new != 8'h00 && scan_cnt_r != CNT_MAX) begin
      cnt_new = scan_cnt_r + 8'd1;
    end
    res.out_row      = a_r.row;
    res.out_column   = a_r.column;
    res.key_down     = a_r.in_range ? rb_new[a_r.column] : 1'b0;
    res.row_state    = a_r.in_range ? rb_new : 16'h0000;
    res.active_count = cnt_new;
    res.scan_done    = a_r.last;
  end

  // History storage: write on retire, registered read on load.
  always_ff @(posedge clk) begin
    if (out_adv && a_r.in_range) begin
      hist_mem[a_idx] <= h_new;
    end
    if (a_load) begin
      mem_q_r <= hist_mem[q_idx];
    end
  end

  always_ff @(posedge clk) begin
    if (a_load) begin
      a_r <= pop_data;
    end
    if (out_adv) begin
      out_r <= res;
    end
    if (out_adv && a_r.in_range) begin
      fwd_idx_r <= a_idx;
      fwd_h_r   <= h_new;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      a_vld_r    <= 1'b0;
      out_vld_r  <= 1'b0;
      fwd_vld_r  <= 1'b0;
      hist_vld_r <= '0;
      scan_cnt_r <= 8'h00;
      for (int i = 0; i < ROWS; i++) begin
        row_bits_r[i] <= 16'h0000;
      end
    end else begin
      if (a_load) begin
        a_vld_r <= 1'b1;
      end else if (out_adv) begin
        a_vld_r <= 1'b0;
      end
      if (out_adv) begin
        out_vld_r  <= 1'b1;
        scan_cnt_r <= a_r.last ? 8'h00 : cnt_new;
      end else if (out_ch.ready) begin
        out_vld_r <= 1'b0;
      end
      if (out_adv && a_r.in_range) begin
        fwd_vld_r         <= 1'b1;
        hist_vld_r[a_idx] <= 1'b1;
        row_bits_r[a_row] <= rb_new;
      end
    end
  end

  assign out_ch.valid = out_vld_r;
  assign out_ch.data  = out_r;

  a_kd_in_row: assert property (@(posedge clk) disable iff (!rst_n)
    out_vld_r |-> out_r.key_down == out_r.row_state[out_r.out_column])
    else $error("key_down disagrees with row_state");

  a_cnt_clear: assert property (@(posedge clk) disable iff (!rst_n)
    out_adv && a_r.last |=> scan_cnt_r == 8'h00)
    else $error("scan counter not cleared after end of scan");

  a_oor_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_adv && !a_r.in_range |=> out_r.key_down == 1'b0 && out_r.row_state == 16'h0000)
    else $error("out-of-range row produced key state");

  a_hist_mark: assert property (@(posedge clk) disable iff (!rst_n)
    out_adv && a_r.in_range |=> hist_vld_r[$past(a_idx)] && fwd_idx_r == $past(a_idx))
    else $error("history write not recorded");

endmodule

>>> tb/key_matrix_debounce_encoder_unit_test.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Key matrix debounce and encoder unit testbench
// Drives sampled switches as matrix scans (held keys with contact bounce, a
// rotary encoder in quadrature, random noise), predicts every debounced
// result in order and compares each field of each result. Runs through
// several level and encoder timeout settings, with random idling on both
// channels and a long output stall.
// ----------------------------------------------------------------------------
module key_matrix_debounce_encoder_unit_test;
  import kmd_pkg::*;

  localparam int KEY_ROWS = 8;
  localparam int KEY_COUNT = KEY_ROWS * COLS;

  logic clk;
  logic rst_n;

  kmd_in_if in_ch ();
  kmd_out_if out_ch ();
  kmd_cfg_if cfg_ch ();

  key_matrix_debounce_encoder_unit #(
    .ROWS(KEY_ROWS)
  ) dut (
    .clk   (clk),
    .rst_n (rst_n),
    .in_ch (in_ch),
    .out_ch(out_ch),
    .cfg_ch(cfg_ch)
  );

  // debounce predictor state
  cfg_t        cur_cfg;
  logic [7:0]  key_hist [KEY_COUNT];
  logic [15:0] row_word [KEY_ROWS];
  logic        enc_phase [2];
  logic [2:0]  enc_filter;
  logic [15:0] enc_stamp;
  logic [7:0]  active_cnt;

  out_item_t awaited_key_results [$];
  int        error_count;
  int        hold_cycles;
  bit        in_gaps_on;
  bit        out_gaps_on;

  // scan generator state
  logic        key_held [KEY_COUNT];
  logic [15:0] scan_time;
  int          quad_pos;
  bit          quad_fwd;

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  initial begin
    #1_000_000;
    $display("DONE: errors detected");
    $finish;
  end

  function automatic logic [7:0] encoder_detent(input logic dir, input logic lvl,
                                               input logic [15:0] now);
    logic [2:0]  target;
    logic [15:0] elapsed;
    target = dir ? FILTER_MASK : 3'b000;
    elapsed = now - enc_stamp;
    if (elapsed > cur_cfg.encoder_idle_ms) enc_filter = target;
    if (lvl != enc_phase[dir]) begin
      enc_phase[dir] = lvl;
      if (!lvl && !enc_phase[!dir]) begin
        enc_filter = {enc_filter[1:0], dir};
        if (enc_filter == target) begin
          enc_stamp = now;
          return cur_cfg.down_level;
        end
      end
    end
    return 8'h00;
  endfunction

  function automatic out_item_t predict_key_result(input in_item_t req);
    out_item_t   res;
    logic [7:0]  sample;
    logic [7:0]  hist;
    logic [15:0] mask;
    int          idx;
    res = '0;
    res.out_row = req.row;
    res.out_column = req.column;
    res.scan_done = req.last_in_scan;
    if (int'(req.row) < KEY_ROWS) begin
      idx = int'(req.row) * COLS + int'(req.column);
      mask = 16'd1 << req.column;
      if (req.row < 3'd2 && req.column == ENC_COL)
        sample = encoder_detent(req.row[0], req.key_pressed, req.time_ms);
      else
        sample = req.key_pressed ? RAW_DOWN : 8'h00;
      hist = (key_hist[idx] >> 1) | sample;
      key_hist[idx] = hist;
      if (hist >= cur_cfg.down_level) row_word[req.row] = row_word[req.row] | mask;
      else if (hist <= cur_cfg.up_level) row_word[req.row] = row_word[req.row] & ~mask;
      if (hist != 8'h00 && active_cnt != CNT_MAX) active_cnt = active_cnt + 8'd1;
      res.row_state = row_word[req.row];
      res.key_down = |(row_word[req.row] & mask);
    end
    res.active_count = active_cnt;
    if (req.last_in_scan) active_cnt = 8'h00;
    return res;
  endfunction

  function automatic in_item_t make_sample(input logic [2:0] row, input logic [3:0] column,
                                           input logic lvl, input logic [15:0] stamp,
                                           input logic last);
    in_item_t req;
    req.row = row;
    req.column = column;
    req.key_pressed = lvl;
    req.time_ms = stamp;
    req.last_in_scan = last;
    return req;
  endfunction

  task automatic report_mismatch(input string what, input logic [15:0] got,
                                 input logic [15:0] want);
    error_count++;
    $display("MISMATCH %s: got %0h expected %0h at %0t", what, got, want, $realtime);
  endtask

  task automatic check_field(input string what, input logic [15:0] got,
                             input logic [15:0] want);
    if (got !== want) report_mismatch(what, got, want);
  endtask

  always @(posedge clk) begin : check_results
    out_item_t want;
    if (rst_n && out_ch.valid === 1'b1 && out_ch.ready === 1'b1) begin
      if (awaited_key_results.size() == 0) begin
        report_mismatch("result with no pending request", 16'(out_ch.data.out_column),
                        16'h0000);
      end else begin
        want = awaited_key_results.pop_front();
        check_field("out_row", 16'(out_ch.data.out_row), 16'(want.out_row));
        check_field("out_column", 16'(out_ch.data.out_column), 16'(want.out_column));
        check_field("key_down", 16'(out_ch.data.key_down), 16'(want.key_down));
        check_field("row_state", out_ch.data.row_state, want.row_state);
        check_field("active_count", 16'(out_ch.data.active_count), 16'(want.active_count));
        check_field("scan_done", 16'(out_ch.data.scan_done), 16'(want.scan_done));
      end
    end
  end

  initial begin : drive_result_ready
    out_ch.ready = 1'b0;
    forever begin
      @(negedge clk);
      if (hold_cycles > 0) begin
        out_ch.ready <= 1'b0;
        hold_cycles--;
      end else begin
        out_ch.ready <= !(out_gaps_on && $urandom_range(99) < 15);
      end
    end
  end

  task automatic send_sample(input in_item_t req);
    @(negedge clk);
    while (in_gaps_on && $urandom_range(99) < 15) begin
      in_ch.valid <= 1'b0;
      @(negedge clk);
    end
    in_ch.valid <= 1'b1;
    in_ch.data <= req;
    do @(posedge clk); while (in_ch.ready !== 1'b1);
    awaited_key_results.push_back(predict_key_result(req));
  endtask

  task automatic drain_results();
    @(negedge clk);
    in_ch.valid <= 1'b0;
    while (awaited_key_results.size() != 0) @(posedge clk);
  endtask

  task automatic write_register(input cfg_reg_t idx, input logic [15:0] value);
    @(negedge clk);
    cfg_ch.valid <= 1'b1;
    cfg_ch.index <= idx;
    cfg_ch.data <= value;
    do @(posedge clk); while (cfg_ch.ready !== 1'b1);
    case (idx)
      REG_DOWN_LEVEL: cur_cfg.down_level = value[7:0];
      REG_UP_LEVEL:   cur_cfg.up_level = value[7:0];
      REG_ENC_IDLE:   cur_cfg.encoder_idle_ms = value;
      default: ;
    endcase
    @(negedge clk);
    cfg_ch.valid <= 1'b0;
  endtask

  task automatic set_levels(input logic [7:0] down, input logic [7:0] up,
                            input logic [15:0] idle_ms);
    write_register(REG_DOWN_LEVEL, {8'($urandom), down});
    write_register(REG_UP_LEVEL, {8'($urandom), up});
    write_register(REG_ENC_IDLE, idle_ms);
  endtask

  // One scan covers a small window of the matrix plus, in most scans, both encoder phases.
  task automatic run_scans(input int n_items);
    in_item_t scan_q [$];
    int       sent;
    int       nr;
    int       nc;
    int       r0;
    int       c0;
    int       r;
    int       c;
    logic     lvl;
    sent = 0;
    while (sent < n_items) begin
      scan_q.delete();
      scan_time += 16'($urandom_range(1, 4));
      if ($urandom_range(99) < 5) scan_time += 16'($urandom_range(300, 65535));
      if ($urandom_range(99) < 70) begin
        if ($urandom_range(99) < 50) quad_pos = quad_fwd ? (quad_pos + 1) % 4 : (quad_pos + 3) % 4;
        if (quad_pos == 0 && $urandom_range(99) < 25) quad_fwd = !quad_fwd;
        scan_q.push_back(make_sample(3'd0, ENC_COL, quad_pos == 1 || quad_pos == 2,
                                     scan_time, 1'b0));
        scan_q.push_back(make_sample(3'd1, ENC_COL, quad_pos >= 2, scan_time, 1'b0));
      end
      nr = $urandom_range(1, 2);
      nc = $urandom_range(2, 5);
      r0 = $urandom_range(0, KEY_ROWS - 1);
      c0 = $urandom_range(0, COLS - 1);
      for (int i = 0; i < nr; i++) begin
        for (int j = 0; j < nc; j++) begin
          r = (r0 + i) % KEY_ROWS;
          c = (c0 + j) % COLS;
          if (!(r < 2 && c == int'(ENC_COL))) begin
            if ($urandom_range(99) < 12) key_held[r * COLS + c] = !key_held[r * COLS + c];
            lvl = key_held[r * COLS + c] ^ ($urandom_range(99) < 10);
            scan_q.push_back(make_sample(3'(r), 4'(c), lvl, scan_time, 1'b0));
          end
        end
      end
      scan_q[scan_q.size() - 1].last_in_scan = 1'b1;
      foreach (scan_q[k]) begin
        if ($urandom_range(99) < 10) send_sample(in_item_t'($urandom));
        else send_sample(scan_q[k]);
        sent++;
      end
    end
  endtask

  task automatic test_directed_defaults();
    for (int i = 0; i < 8; i++) send_sample(make_sample(3'd2, 4'd5, 1'b1, 16'(i), 1'b0));
    send_sample(make_sample(3'd2, 4'd5, 1'b0, 16'd8, 1'b0));
    send_sample(make_sample(3'd7, 4'd15, 1'b1, 16'hFFFF, 1'b0));
    send_sample(make_sample(3'd0, 4'd0, 1'b0, 16'd0, 1'b1));
    // encoder idle timeout reloads the filter, so one release is a detent
    send_sample(make_sample(3'd1, ENC_COL, 1'b1, 16'd1000, 1'b0));
    send_sample(make_sample(3'd1, ENC_COL, 1'b0, 16'd1001, 1'b0));
    for (int k = 0; k < 3; k++) begin
      send_sample(make_sample(3'd0, ENC_COL, 1'b1, 16'(1002 + 2 * k), 1'b0));
      send_sample(make_sample(3'd0, ENC_COL, 1'b0, 16'(1003 + 2 * k), 1'b0));
    end
    send_sample(make_sample(3'd0, ENC_COL, 1'b0, 16'd1010, 1'b1));
    drain_results();
  endtask

  task automatic test_count_saturation();
    for (int i = 0; i < 270; i++)
      send_sample(make_sample(3'($urandom), 4'($urandom), $urandom_range(99) < 80,
                              16'($urandom), i == 269));
    drain_results();
  endtask

  task automatic test_typical_levels();
    set_levels(8'hE0, 8'h1F, 16'd60);
    run_scans(100);
    drain_results();
  endtask

  task automatic test_extreme_levels();
    set_levels(8'h00, 8'hFF, 16'd0);
    run_scans(50);
    drain_results();
    set_levels(8'hFF, 8'hFF, 16'hFFFF);
    run_scans(50);
    drain_results();
    set_levels(8'h80, 8'h7F, 16'd1);
    run_scans(50);
    drain_results();
  endtask

  task automatic test_output_stall();
    set_levels(8'hF0, 8'h0F, 16'd400);
    @(posedge clk);
    hold_cycles = 300;
    run_scans(40);
    drain_results();
    run_scans(20);
    drain_results();
  endtask

  task automatic test_no_idling();
    @(posedge clk);
    in_gaps_on = 1'b0;
    out_gaps_on = 1'b0;
    run_scans(100);
    drain_results();
    in_gaps_on = 1'b1;
    out_gaps_on = 1'b1;
  endtask

  task automatic test_random_levels();
    repeat (3) begin
      set_levels(8'($urandom), 8'($urandom), 16'($urandom_range(0, 800)));
      run_scans(40);
      drain_results();
    end
  endtask

  initial begin
    cur_cfg.down_level = DOWN_RST;
    cur_cfg.up_level = UP_RST;
    cur_cfg.encoder_idle_ms = IDLE_MS_RST;
    foreach (key_hist[i]) key_hist[i] = 8'h00;
    foreach (key_held[i]) key_held[i] = 1'b0;
    foreach (row_word[i]) row_word[i] = 16'h0000;
    enc_phase[0] = 1'b0;
    enc_phase[1] = 1'b0;
    enc_filter = 3'b000;
    enc_stamp = 16'h0000;
    active_cnt = 8'h00;
    error_count = 0;
    hold_cycles = 0;
    in_gaps_on = 1'b1;
    out_gaps_on = 1'b1;
    scan_time = 16'd2000;
    quad_pos = 0;
    quad_fwd = 1'b1;
    rst_n = 1'b0;
    in_ch.valid = 1'b0;
    in_ch.data = '0;
    cfg_ch.valid = 1'b0;
    cfg_ch.index = REG_DOWN_LEVEL;
    cfg_ch.data = '0;
    repeat (11) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    test_directed_defaults();
    test_count_saturation();
    test_typical_levels();
    test_extreme_levels();
    test_output_stall();
    test_no_idling();
    test_random_levels();

    repeat (6) @(posedge clk);
    if (error_count == 0 && awaited_key_results.size() == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule

>>> files.f
rtl/kmd_pkg.sv
rtl/kmd_in_if.sv
rtl/kmd_out_if.sv
rtl/kmd_cfg_if.sv
rtl/kmd_front.sv
rtl/kmd_fifo.sv
rtl/kmd_back.sv
rtl/key_matrix_debounce_encoder_unit.sv
tb/key_matrix_debounce_encoder_unit_test.sv
